FILE: hw/rtl/key_matrix_event_scanner_macros.svh
// Assertion macros for the key matrix event scanner checker.
// No dependencies; included by the checker file.
`ifndef KEY_MATRIX_EVENT_SCANNER_MACROS_SVH
`define KEY_MATRIX_EVENT_SCANNER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define KMES_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define KMES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/kmes_pkg.sv
// Shared types and constants of the key matrix event scanner.
// No dependencies; used by the top level and the checker.
package kmes_pkg;

	// Field widths
	localparam int NOW_W  = 32;
	localparam int KEYS_W = 30;
	localparam int CODE_W = 5;
	localparam int ACT_W  = 2;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;
	localparam int MAP_DIM_W = 3;

	// Stamp marking a reported key
	localparam logic [NOW_W-1:0] STAMP_DONE = '1;

	// Event actions
	localparam logic [ACT_W-1:0] ACT_DOWN = 2'd0;
	localparam logic [ACT_W-1:0] ACT_UP   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_LONG = 2'd2;

	// Fixed event codes
	localparam logic [CODE_W-1:0] CODE_NONE        = 5'd0;
	localparam logic [CODE_W-1:0] CODE_KNOB_LEFT   = 5'd27;
	localparam logic [CODE_W-1:0] CODE_KNOB_RIGHT  = 5'd28;
	localparam logic [CODE_W-1:0] CODE_KNOB_BUTTON = 5'd29;

	// Register indexes
	localparam logic [IDX_W-1:0] CFG_LONG_PRESS   = 2'd0;
	localparam logic [IDX_W-1:0] CFG_RELEASE_GRD  = 2'd1;
	localparam logic [IDX_W-1:0] CFG_KNOB_DEBNC   = 2'd2;
	localparam logic [IDX_W-1:0] CFG_KNOB_LONG    = 2'd3;

	// Matrix cell to control code, [row][col], zero for unmapped cells
	localparam logic [CODE_W-1:0] KEY_MAP [8][8] = '{
		'{5'd6,  5'd11, 5'd16, 5'd18, 5'd1, 5'd0, 5'd0, 5'd0},
		'{5'd7,  5'd12, 5'd17, 5'd19, 5'd2, 5'd0, 5'd0, 5'd0},
		'{5'd8,  5'd13, 5'd0,  5'd20, 5'd3, 5'd0, 5'd0, 5'd0},
		'{5'd9,  5'd14, 5'd25, 5'd0,  5'd4, 5'd0, 5'd0, 5'd0},
		'{5'd10, 5'd15, 5'd26, 5'd0,  5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0,  5'd0,  5'd0,  5'd0,  5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0,  5'd0,  5'd0,  5'd0,  5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd0,  5'd0,  5'd0,  5'd0,  5'd0, 5'd0, 5'd0, 5'd0}
	};

	function automatic logic [CODE_W-1:0] key_code_of(
		input logic [MAP_DIM_W-1:0] row,
		input logic [MAP_DIM_W-1:0] col
	);
		return KEY_MAP[row][col];
	endfunction

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_KNOB_A,
		ST_KNOB_B,
		ST_ENC,
		ST_FLUSH
	} kmes_state_t;

	// One key event
	typedef struct packed {
		logic [ACT_W-1:0]  act;
		logic [CODE_W-1:0] code;
	} kmes_evt_t;

endpackage

FILE: hw/rtl/key_matrix_event_scanner.sv
// Key matrix event scanner: walks the key matrix, knob button and encoder
// once per scan transaction and streams the resulting key events. Depends on kmes_pkg.
// An event is held one step in a pending register so the final one can be marked last.
// A new scan is taken only in idle, once the previous scan has been walked and flushed;
// the walk reads one stamp per cell and uses one shared subtract/compare unit. Result
// backpressure adds stall cycles.
// Reset: async active low; all keys idle, knob armed, registers at defaults.
module key_matrix_event_scanner #(
	parameter int NUM_ROWS = 5,
	parameter int NUM_COLS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	// scan input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // now_ms[31:0], keys_pressed[61:32], knob_pressed[62],
	                              // phase_left[63], phase_right[64], zero fill
	// event output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // key_code[4:0], action[6:5], zero fill
	output logic        m_tlast,  // last_event
	// register writes
	input  logic                      cfg_we,
	input  logic [kmes_pkg::IDX_W-1:0] cfg_idx,
	input  logic [kmes_pkg::CFG_W-1:0] cfg_data
);
	import kmes_pkg::*;

	localparam int CELLS = NUM_ROWS * NUM_COLS;
	localparam int BIT_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int COL_W = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
	localparam int EXT_W = ((1 << BIT_W) > KEYS_W) ? (1 << BIT_W) : KEYS_W;

	// Configuration registers
	logic [CFG_W-1:0] long_press_q, release_guard_q, knob_debounce_q, knob_long_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q    <= 16'd500;
			release_guard_q <= 16'd100;
			knob_debounce_q <= 16'd50;
			knob_long_q     <= 16'd500;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_LONG_PRESS:  long_press_q    <= cfg_data;
				CFG_RELEASE_GRD: release_guard_q <= cfg_data;
				CFG_KNOB_DEBNC:  knob_debounce_q <= cfg_data;
				CFG_KNOB_LONG:   knob_long_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer state and latched scan
	kmes_state_t state_q, state_d;
	logic [NOW_W-1:0]  now_q;
	logic [KEYS_W-1:0] keys_q;
	logic knob_q, left_q, right_q;
	logic in_acc;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_q   <= s_tdata[31:0];
			keys_q  <= s_tdata[61:32];
			knob_q  <= s_tdata[62];
			left_q  <= s_tdata[63];
			right_q <= s_tdata[64];
		end
	end

	// Walk counters (column-major), fetch side
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [BIT_W-1:0] bit_q;
	logic fetch_done_q;
	logic last_cell;
	logic [EXT_W-1:0] keys_ext;
	logic go;

	assign last_cell = (row_q == ROW_W'(NUM_ROWS - 1)) && (col_q == COL_W'(NUM_COLS - 1));
	assign keys_ext  = EXT_W'(keys_q);

	// Stamp memory with per-entry valid bits (invalid reads as idle)
	logic [NOW_W-1:0] stamp_mem [CELLS];
	logic [CELLS-1:0] stamp_vld_q;
	logic mem_we;
	logic [NOW_W-1:0] mem_wdata;

	// Evaluate stage
	logic             v_s1;
	logic [NOW_W-1:0] rd_s1;
	logic             rdv_s1;
	logic [CODE_W-1:0] code_s1;
	logic             pressed_s1;
	logic [BIT_W-1:0] bit_s1;
	logic [NOW_W-1:0] stamp_s1;

	assign stamp_s1 = rdv_s1 ? rd_s1 : '0;

	logic fetch_en;
	assign fetch_en = (state_q == ST_SCAN) && !fetch_done_q && go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q        <= '0;
			col_q        <= '0;
			bit_q        <= '0;
			fetch_done_q <= 1'b0;
			v_s1         <= 1'b0;
		end else if (in_acc) begin
			row_q        <= '0;
			col_q        <= '0;
			bit_q        <= '0;
			fetch_done_q <= 1'b0;
			v_s1         <= 1'b0;
		end else if (state_q == ST_SCAN && go) begin
			v_s1 <= !fetch_done_q;
			if (!fetch_done_q) begin
				if (last_cell) begin
					fetch_done_q <= 1'b1;
				end else if (row_q == ROW_W'(NUM_ROWS - 1)) begin
					row_q <= '0;
					col_q <= col_q + 1'b1;
					bit_q <= BIT_W'(col_q) + 1'b1;
				end else begin
					row_q <= row_q + 1'b1;
					bit_q <= bit_q + BIT_W'(NUM_COLS);
				end
			end
		end
	end

	// Memory read into the evaluate stage
	always_ff @(posedge clk) begin
		if (fetch_en) begin
			rd_s1      <= stamp_mem[bit_q];
			rdv_s1     <= stamp_vld_q[bit_q];
			code_s1    <= key_code_of(MAP_DIM_W'(row_q), MAP_DIM_W'(col_q));
			pressed_s1 <= keys_ext[bit_q];
			bit_s1     <= bit_q;
		end
	end

	// Memory write from the evaluate stage
	always_ff @(posedge clk) begin
		if (mem_we && go) begin
			stamp_mem[bit_s1] <= mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_vld_q <= '0;
		end else if (mem_we && go) begin
			stamp_vld_q[bit_s1] <= 1'b1;
		end
	end

	// Knob and encoder state
	logic [NOW_W-1:0] knob_stamp_q, knob_stamp_d;
	logic was_q, was_d, armed_q, armed_d, pwh_q, pwh_d;

	// Shared subtract and compare unit
	logic [NOW_W-1:0] sub_b, delta;
	logic [CFG_W-1:0] lim_a, lim_b;
	logic gt_a, gt_b;

	assign delta = now_q - sub_b;
	assign gt_a  = delta > NOW_W'(lim_a);
	assign gt_b  = delta > NOW_W'(lim_b);

	// Event staging: pending event plus output register
	kmes_evt_t pend_q, out_q, emit_evt;
	logic pend_v_q, out_v_q, out_last_q;
	logic emit_req, out_free;

	assign out_free = !out_v_q || m_tready;
	assign go       = !emit_req || !pend_v_q || out_free;

	// Next state, shared-unit operands, events and state updates
	always_comb begin
		logic busy;
		logic armed_eff;
		logic long_fire;
		busy      = 1'b0;
		armed_eff = 1'b0;
		long_fire = 1'b0;
		state_d      = state_q;
		sub_b        = stamp_s1;
		lim_a        = long_press_q;
		lim_b        = release_guard_q;
		emit_req     = 1'b0;
		emit_evt     = '{act: ACT_DOWN, code: CODE_NONE};
		mem_we       = 1'b0;
		mem_wdata    = '0;
		knob_stamp_d = knob_stamp_q;
		was_d        = was_q;
		armed_d      = armed_q;
		pwh_d        = pwh_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (v_s1 && code_s1 != CODE_NONE) begin
					busy = (stamp_s1 != '0) && (stamp_s1 != STAMP_DONE);
					if (busy) begin
						if (gt_a) begin
							mem_we    = 1'b1;
							mem_wdata = STAMP_DONE;
							emit_req  = 1'b1;
							emit_evt  = '{act: ACT_LONG, code: code_s1};
						end else if (gt_b && !pressed_s1) begin
							mem_we    = 1'b1;
							mem_wdata = STAMP_DONE;
							emit_req  = 1'b1;
							emit_evt  = '{act: ACT_UP, code: code_s1};
						end
					end else if (pressed_s1 && stamp_s1 != STAMP_DONE) begin
						mem_we    = 1'b1;
						mem_wdata = now_q;
						emit_req  = 1'b1;
						emit_evt  = '{act: ACT_DOWN, code: code_s1};
					end else if (!pressed_s1 && stamp_s1 == STAMP_DONE) begin
						mem_we    = 1'b1;
						mem_wdata = '0;
					end
				end
				if (fetch_done_q && !v_s1) state_d = ST_KNOB_A;
			end
			ST_KNOB_A: begin
				sub_b     = knob_stamp_q;
				lim_a     = knob_long_q;
				armed_eff = armed_q || !knob_q;
				long_fire = armed_eff && knob_q && was_q && gt_a;
				armed_d   = armed_eff && !long_fire;
				if (long_fire) begin
					emit_req     = 1'b1;
					emit_evt     = '{act: ACT_LONG, code: CODE_KNOB_BUTTON};
					was_d        = 1'b0;
					knob_stamp_d = '0;
				end
				if (go) state_d = armed_eff ? ST_KNOB_B : ST_ENC;
			end
			ST_KNOB_B: begin
				sub_b = knob_stamp_q;
				lim_b = knob_debounce_q;
				if (knob_stamp_q == '0) begin
					if (knob_q) begin
						emit_req     = 1'b1;
						emit_evt     = '{act: ACT_DOWN, code: CODE_KNOB_BUTTON};
						knob_stamp_d = now_q;
						was_d        = 1'b1;
					end
				end else if (gt_b && !knob_q) begin
					emit_req     = 1'b1;
					emit_evt     = '{act: ACT_UP, code: CODE_KNOB_BUTTON};
					knob_stamp_d = '0;
					was_d        = 1'b0;
				end
				if (go) state_d = ST_ENC;
			end
			ST_ENC: begin
				if (left_q && right_q) begin
					pwh_d = 1'b1;
				end else if (pwh_q && left_q && !right_q) begin
					emit_req = 1'b1;
					emit_evt = '{act: ACT_DOWN, code: CODE_KNOB_LEFT};
					pwh_d    = 1'b0;
				end else if (pwh_q && !left_q && right_q) begin
					emit_req = 1'b1;
					emit_evt = '{act: ACT_DOWN, code: CODE_KNOB_RIGHT};
					pwh_d    = 1'b0;
				end
				if (go) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!pend_v_q || out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Knob and encoder registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knob_stamp_q <= '0;
			was_q        <= 1'b0;
			armed_q      <= 1'b1;
			pwh_q        <= 1'b0;
		end else if (go) begin
			knob_stamp_q <= knob_stamp_d;
			was_q        <= was_d;
			armed_q      <= armed_d;
			pwh_q        <= pwh_d;
		end
	end

	// Pending event and output register; the last event is known at flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (emit_req && go) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) out_v_q <= 1'b1;
				else if (m_tready) out_v_q <= 1'b0;
			end else if (state_q == ST_FLUSH && pend_v_q && out_free) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_req && go) begin
			pend_q <= emit_evt;
			if (pend_v_q) begin
				out_q      <= pend_q;
				out_last_q <= 1'b0;
			end
		end else if (state_q == ST_FLUSH && pend_v_q && out_free) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {1'b0, out_q.act, out_q.code};
	assign m_tlast  = out_last_q;

endmodule

FILE: hw/rtl/kmes_checker.sv
// Port-level checker for the key matrix event scanner, bound to the top level.
// Depends on kmes_pkg and key_matrix_event_scanner_macros.svh.
`include "key_matrix_event_scanner_macros.svh"

module kmes_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);
	import kmes_pkg::*;

	// Event fields as seen on the output port
	logic [CODE_W-1:0] ev_code;
	logic [ACT_W-1:0]  ev_act;
	logic              act_legal;
	logic              enc_step;

	assign ev_code   = m_tdata[CODE_W-1:0];
	assign ev_act    = m_tdata[CODE_W+ACT_W-1:CODE_W];
	assign act_legal = (ev_act == ACT_DOWN) || (ev_act == ACT_UP) || (ev_act == ACT_LONG);
	assign enc_step  = (ev_code == CODE_KNOB_LEFT) || (ev_code == CODE_KNOB_RIGHT);

	// A stalled event transaction stays offered
	`KMES_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "event dropped while stalled")

	// The scanner is busy once a scan is taken: no second scan right after one is taken
	`KMES_ASSERT_NEXT(a_one_scan, s_tvalid && s_tready, !s_tready, "scan taken while busy")

	// Every event carries a mapped code and a defined action
	`KMES_ASSERT_NOW(a_evt_legal, m_tvalid, (ev_code != CODE_NONE) && act_legal && !m_tdata[7], "illegal event")

	// Encoder steps are always reported as down
	`KMES_ASSERT_NOW(a_enc_down, m_tvalid && enc_step, ev_act == ACT_DOWN, "encoder step not down")

endmodule

bind key_matrix_event_scanner kmes_checker u_kmes_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
